// ===== hdl/bse_pkg.sv =====
// bse_pkg: shared types and constants of the bubble sort engine.
// No dependencies; imported by every module of the block.
package bse_pkg;

  localparam int KEY_W = 10;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t key_value;
    logic last_of_set;
  } in_item_t;

  typedef struct packed {
    key_t sorted_value;
    logic final_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_START,
    ST_PASS_FIRST,
    ST_PASS_STEP,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } bse_state_t;

endpackage

// ===== hdl/bubble_sort_engine.sv =====
// bubble_sort_engine: top level, load/sort/emit sequencer and output register.
// Depends on bse_pkg, bse_store and bse_cmp.
//
//   channel | direction | type        | transfer when
//   in_     | input     | in_item_t   | in_valid && in_ready
//   out_    | output    | out_item_t  | out_valid && out_ready
//
// Loading accepts one item per cycle; in_ready is high only while loading.
// Sort of n keys: each pass step does one memory write and one compare, and
// reads the next key unless it is the last step; the carried key moves up a pass.
// Emit: each key goes through the registered memory read, then the output register.
// Reset clears control state only; the key memory is not cleared.
// A stalled output holds the sequencer until the transfer completes.
module bubble_sort_engine
  import bse_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  bse_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  key_t             cur_r, cur_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  key_t             wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  key_t             rd_data;
  key_t             cmp_lo, cmp_hi;

  logic             in_xfer;
  logic             full;
  logic [CNT_W-1:0] n_after;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_p2;
  logic [CNT_W-1:0] len_m1;
  logic             out_load;

  bse_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bse_cmp u_cmp (
    .a (cur_r),
    .b (rd_data),
    .lo(cmp_lo),
    .hi(cmp_hi)
  );

  assign in_ready = (state_r == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (count_r >= CNT_W'(CAPACITY));
  assign n_after  = full ? count_r : count_r + CNT_W'(1);
  assign idx_p1   = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_p2   = CNT_W'(idx_r) + CNT_W'(2);
  assign len_m1   = len_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = in_data.key_value;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (!full) begin
            wr_en     = 1'b1;
            count_nxt = n_after;
          end
          if (in_data.last_of_set) begin
            len_nxt   = n_after;
            idx_nxt   = '0;
            state_nxt = (n_after >= CNT_W'(2)) ? ST_SORT_START : ST_EMIT_RD;
          end
        end
      end
      ST_SORT_START: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_PASS_FIRST;
      end
      ST_PASS_FIRST: begin
        cur_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = AW'(1);
        idx_nxt   = '0;
        state_nxt = ST_PASS_STEP;
      end
      ST_PASS_STEP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = cmp_lo;
        cur_nxt = cmp_hi;
        if (idx_p2 == len_r) begin
          state_nxt = ST_PASS_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[AW-1:0];
          idx_nxt = idx_p1[AW-1:0];
        end
      end
      ST_PASS_END: begin
        // park the carried maximum; start the next, shorter pass or go on to emit
        wr_en   = 1'b1;
        wr_addr = len_m1[AW-1:0];
        wr_data = cur_r;
        len_nxt = len_m1;
        if (len_r > CNT_W'(2)) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = ST_PASS_FIRST;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_load                  = 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.sorted_value = rd_data;
          out_data_nxt.final_flag   = (idx_p1 == count_r);
          if (idx_p1 == count_r) begin
            count_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_p1[AW-1:0];
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_sort_wr_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (state_r == ST_PASS_STEP || state_r == ST_PASS_END))
      |-> (CNT_W'(wr_addr) < len_r))
    else $error("sort write outside current pass");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_data_nxt.final_flag) |=> (state_r == ST_LOAD && count_r == '0))
    else $error("final key did not close the run");

  a_emit_only_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD) |-> (idx_p1 <= count_r))
    else $error("emit index past stored keys");

endmodule

// ===== hdl/bse_store.sv =====
// bse_store: key memory, one write port and one registered read port.
// Depends on bse_pkg for the key type.
module bse_store
  import bse_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  key_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output key_t          rd_data
);

  key_t mem [DEPTH];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bse_cmp.sv =====
// bse_cmp: compare-and-order unit, returns the smaller and larger key.
// Depends on bse_pkg for the key type.
module bse_cmp
  import bse_pkg::*;
(
  input  key_t a,
  input  key_t b,
  output key_t lo,
  output key_t hi
);

  logic swap;

  // equal keys keep their order
  assign swap = (a > b);
  assign lo   = swap ? b : a;
  assign hi   = swap ? a : b;

endmodule
